[sv/rdd_pkg.sv]
// shared types, widths and codes for the ring deque unit
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_W  = 11;
  localparam int unsigned CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT_FRONT = 3'd0,
    FUNC_DELETE_VALUE = 3'd1,
    FUNC_DELETE_FRONT = 3'd2,
    FUNC_DELETE_BACK  = 3'd3,
    FUNC_READ         = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_RANGE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_WAIT
  } state_e;

  // single-port store access from the sequencer
  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

[sv/rdd_req_if.sv]
// request channel interface: operation, key and position
`timescale 1ns / 1ps
`default_nettype none

interface rdd_req_if
  import rdd_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] key;
  logic [POS_W-1:0]         position;

  modport source (output valid, output func, output key, output position, input ready);
  modport sink   (input valid, input func, input key, input position, output ready);
endinterface

`default_nettype wire

[sv/rdd_rsp_if.sv]
// response channel interface: status, read data and entry count
`timescale 1ns / 1ps
`default_nettype none

interface rdd_rsp_if
  import rdd_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_data;
  logic [ENTRY_W-1:0]       entry_count;

  modport source (output valid, output status, output read_data, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[sv/rdd_ram.sv]
// single-port circular store with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rdd_ram
  import rdd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire ram_req_t          req_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/rdd_wrap_add.sv]
// shared index adder: (base + offset) modulo the ring capacity
`timescale 1ns / 1ps
`default_nettype none

module rdd_wrap_add
  import rdd_pkg::*;
(
  input  wire logic [IDX_W-1:0] base_i,
  input  wire logic [IDX_W-1:0] off_i,
  output      logic [IDX_W-1:0] sum_o
);

  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

  logic [IDX_W:0] raw;
  logic [IDX_W:0] wrapped;

  always_comb begin
    raw     = {1'b0, base_i} + {1'b0, off_i};
    wrapped = (raw >= CAP_EXT) ? (raw - CAP_EXT) : raw;
    sum_o   = wrapped[IDX_W-1:0];
  end

endmodule

`default_nettype wire

[sv/rdd_ctrl.sv]
// sequencer: front/count registers, scan and shift walk, response register
`timescale 1ns / 1ps
`default_nettype none

module rdd_ctrl
  import rdd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rdd_req_if.sink                req_i,
  rdd_rsp_if.source              rsp_o,
  output      ram_req_t          ram_req_o,
  input  wire logic [DATA_W-1:0] ram_rdata_i
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] DEC_OFF = IDX_W'(CAPACITY - 1);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [DATA_W-1:0] key_q, key_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [CNT_W-1:0]    count_q, count_d;

  logic             accept;
  logic             occ_zero;
  logic             occ_full;
  logic             pos_oob;
  logic             key_hit;
  logic [CNT_W-1:0] k_inc;
  logic [IDX_W-1:0] add_off;
  logic [IDX_W-1:0] add_sum;

  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  logic [DATA_W-1:0]   fin_data;

  rdd_wrap_add u_wrap_add (
    .base_i (front_q),
    .off_i  (add_off),
    .sum_o  (add_sum)
  );

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign occ_zero    = (occ_q == '0);
  assign occ_full    = (occ_q >= CAP_CNT);
  assign pos_oob     = (CMP_W'(req_i.position) >= CMP_W'(occ_q));
  assign key_hit     = (ram_rdata_i == key_q);
  assign k_inc       = k_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_DELETE_VALUE: begin
              if (!occ_zero) state_d = S_SCAN_RD;
            end
            FUNC_READ: begin
              if (!occ_zero && !pos_oob) state_d = S_READ_WAIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (key_hit) begin
          state_d = S_SHIFT_RD;
        end else if (k_inc == occ_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (k_inc < occ_q) begin
          state_d = S_SHIFT_WR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT_WR:  state_d = S_SHIFT_RD;
      S_READ_WAIT: state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    front_d    = front_q;
    occ_d      = occ_q;
    k_d        = k_q;
    key_d      = key_q;
    add_off    = '0;
    ram_req_o  = '0;
    fin        = 1'b0;
    fin_status = STATUS_OK;
    fin_data   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_INSERT_FRONT: begin
              fin = 1'b1;
              if (occ_full) begin
                fin_status = STATUS_FULL;
              end else begin
                add_off         = DEC_OFF;
                front_d         = add_sum;
                occ_d           = occ_q + 1'b1;
                ram_req_o.we    = 1'b1;
                ram_req_o.addr  = add_sum;
                ram_req_o.wdata = req_i.key;
              end
            end
            FUNC_DELETE_VALUE: begin
              if (occ_zero) begin
                fin        = 1'b1;
                fin_status = STATUS_EMPTY;
              end else begin
                key_d = req_i.key;
                k_d   = '0;
              end
            end
            FUNC_DELETE_FRONT: begin
              fin = 1'b1;
              if (occ_zero) begin
                fin_status = STATUS_EMPTY;
              end else begin
                add_off = IDX_W'(1);
                front_d = add_sum;
                occ_d   = occ_q - 1'b1;
              end
            end
            FUNC_DELETE_BACK: begin
              fin = 1'b1;
              if (occ_zero) begin
                fin_status = STATUS_EMPTY;
              end else begin
                occ_d = occ_q - 1'b1;
              end
            end
            FUNC_READ: begin
              if (occ_zero) begin
                fin        = 1'b1;
                fin_status = STATUS_EMPTY;
              end else if (pos_oob) begin
                fin        = 1'b1;
                fin_status = STATUS_RANGE;
              end else begin
                add_off        = IDX_W'(req_i.position);
                ram_req_o.re   = 1'b1;
                ram_req_o.addr = add_sum;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        add_off        = IDX_W'(k_q);
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = add_sum;
      end
      S_SCAN_CMP: begin
        if (!key_hit) begin
          k_d = k_inc;
          if (k_inc == occ_q) begin
            fin        = 1'b1;
            fin_status = STATUS_NOT_FOUND;
          end
        end
      end
      S_SHIFT_RD: begin
        if (k_inc < occ_q) begin
          // fetch the follower of the current slot
          add_off        = IDX_W'(k_inc);
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = add_sum;
        end else begin
          occ_d = occ_q - 1'b1;
          fin   = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        add_off         = IDX_W'(k_q);
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = add_sum;
        ram_req_o.wdata = ram_rdata_i;
        k_d             = k_inc;
      end
      S_READ_WAIT: begin
        fin      = 1'b1;
        fin_data = ram_rdata_i;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // response register; a new result only lands once the slot is free
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    data_d      = data_q;
    count_d     = count_q;
    if (fin) begin
      rsp_valid_d = 1'b1;
      status_d    = fin_status;
      data_d      = fin_data;
      count_d     = occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    key_q    <= key_d;
    status_q <= status_d;
    data_q   <= data_d;
    count_q  <= count_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_data   = data_q;
  assign rsp_o.entry_count = ENTRY_W'(count_q);

endmodule

`default_nettype wire

[sv/ring_deque_delete_by_value_unit.sv]
// ring deque with delete by value: sequencer plus circular store
//
// requests arrive on req_i (func, key, position) and each one returns exactly
// one transaction on rsp_o (status, read_data, entry_count) in request order.
// both channels transfer when valid and ready are high at a rising clk_i edge.
// insert front, delete front, delete back, unused codes and every rejected
// request finish in the accept cycle: the result is valid in the next cycle.
// a read finishes once the registered store read has returned (S_READ_WAIT).
// delete by value walks the entries from the front through one shared index
// adder and the single store port, reading and comparing each entry, then
// moving each following entry one slot toward the front to close the gap.
// req_i.ready is low while an item is in progress and while the response
// register holds an untaken result that is not being taken this cycle.
// a stalled receiver therefore holds at most one result and blocks new work.
// rst_ni (asynchronous, active low) empties the deque and drops any pending
// result; store contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_delete_by_value_unit
  import rdd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdd_req_if.sink   req_i,
  rdd_rsp_if.source rsp_o
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  rdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  rdd_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the ring deque delete-by-value unit
`timescale 1ns / 1ps

module tb_top;
  import rdd_pkg::*;

  // codes 5 to 7 carry no operation
  localparam logic [FUNC_W-1:0] FUNC_NOP_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_NOP_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_NOP_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh80000000;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_data;
    logic [ENTRY_W-1:0]       entry_count;
  } deque_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] key;
    logic [POS_W-1:0]         position;
    logic                     typed;
    deque_result_t            result;
  } directed_row_t;

  logic clk;
  logic rst_n;

  rdd_req_if req_if ();
  rdd_rsp_if rsp_if ();

  ring_deque_delete_by_value_unit u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the deque
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  int unsigned shadow_front;
  int unsigned shadow_count;
  int unsigned peak_count;

  deque_result_t            pending_results [$];
  directed_row_t            directed_rows [$];
  logic signed [DATA_W-1:0] key_pool [8];

  bit no_idle;
  bit hold_output;
  int error_count;
  int result_count;
  int sent_count;
  int status_seen [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic deque_result_t apply_deque_op(input logic [FUNC_W-1:0] func,
                                                   input logic signed [DATA_W-1:0] key,
                                                   input logic [POS_W-1:0] pos);
    deque_result_t res;
    int unsigned   k;
    int unsigned   hit;
    bit            found;
    res        = '0;
    res.status = STATUS_OK;
    found      = 1'b0;
    hit        = 0;
    case (func)
      FUNC_INSERT_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
          shadow_store[shadow_front] = key;
          shadow_count++;
        end
      end
      FUNC_DELETE_VALUE: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          for (k = 0; k < shadow_count && !found; k++) begin
            if (shadow_store[(shadow_front + k) % CAPACITY] == key) begin
              found = 1'b1;
              hit   = k;
            end
          end
          if (!found) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            // close the gap toward the front, wrapping around the ring
            for (k = hit; k + 1 < shadow_count; k++)
              shadow_store[(shadow_front + k) % CAPACITY] =
                shadow_store[(shadow_front + k + 1) % CAPACITY];
            shadow_count--;
          end
        end
      end
      FUNC_DELETE_FRONT: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % CAPACITY;
          shadow_count--;
        end
      end
      FUNC_DELETE_BACK: begin
        if (shadow_count == 0) res.status = STATUS_EMPTY;
        else shadow_count--;
      end
      FUNC_READ: begin
        if (shadow_count == 0) res.status = STATUS_EMPTY;
        else if (pos >= shadow_count) res.status = STATUS_RANGE;
        else res.read_data = shadow_store[(shadow_front + pos) % CAPACITY];
      end
      default: ;
    endcase
    res.entry_count = ENTRY_W'(shadow_count);
    if (shadow_count > peak_count) peak_count = shadow_count;
    return res;
  endfunction

  function automatic directed_row_t typed_row(input logic [FUNC_W-1:0] func,
                                              input logic signed [DATA_W-1:0] key,
                                              input logic [POS_W-1:0] pos,
                                              input logic [STATUS_W-1:0] status,
                                              input logic signed [DATA_W-1:0] data,
                                              input logic [ENTRY_W-1:0] count);
    directed_row_t row;
    row.func               = func;
    row.key                = key;
    row.position           = pos;
    row.typed              = 1'b1;
    row.result.status      = status;
    row.result.read_data   = data;
    row.result.entry_count = count;
    return row;
  endfunction

  function automatic directed_row_t predicted_row(input logic [FUNC_W-1:0] func,
                                                  input logic signed [DATA_W-1:0] key,
                                                  input logic [POS_W-1:0] pos);
    directed_row_t row;
    row          = '0;
    row.func     = func;
    row.key      = key;
    row.position = pos;
    return row;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1: return key_pool[$urandom_range(0, 7)];
      2: begin
        if (shadow_count > 0)
          return shadow_store[(shadow_front + $urandom_range(0, shadow_count - 1)) % CAPACITY];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_read_pos();
    if ($urandom_range(0, 7) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, shadow_count));
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] func,
                         input logic signed [DATA_W-1:0] key,
                         input logic [POS_W-1:0] pos,
                         input logic typed,
                         input deque_result_t typed_result);
    int            gap;
    deque_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= func;
    req_if.key      <= key;
    req_if.position <= pos;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_deque_op(func, key, pos);
    pending_results.push_back(typed ? typed_result : predicted);
    sent_count++;
  endtask

  task automatic random_ops(input int n, input int insert_pct, input int hold_at);
    int                       r;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] key;
    logic [POS_W-1:0]         pos;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) func = FUNC_INSERT_FRONT;
      else if (r < insert_pct + 20) func = FUNC_DELETE_VALUE;
      else if (r < insert_pct + 30) func = FUNC_DELETE_FRONT;
      else if (r < insert_pct + 40) func = FUNC_DELETE_BACK;
      else if (r < 96) func = FUNC_READ;
      else func = FUNC_W'($urandom_range(FUNC_NOP_5, FUNC_NOP_7));
      key = pick_key();
      pos = (func == FUNC_READ) ? pick_read_pos() : POS_W'($urandom);
      if (i == hold_at) hold_output = 1'b1;
      send_op(func, key, pos, 1'b0, '0);
    end
  endtask

  // response side: random backpressure plus one long hold-off on request
  initial begin : response_pacing
    int gap;
    rsp_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_output) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t observed;
    deque_result_t wanted;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      observed = {rsp_if.status, rsp_if.read_data, rsp_if.entry_count};
      result_count++;
      status_seen[observed.status]++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected response: status %0d read_data %0h entry_count %0d",
                   observed.status, observed.read_data, observed.entry_count);
      end else begin
        wanted = pending_results.pop_front();
        if (observed !== wanted) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch on response %0d: status %0d/%0d read_data %0h/%0h count %0d/%0d",
                     result_count, wanted.status, observed.status, wanted.read_data,
                     observed.read_data, wanted.entry_count, observed.entry_count);
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] key;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.func     = '0;
    req_if.key      = '0;
    req_if.position = '0;
    no_idle         = 1'b0;
    hold_output     = 1'b0;
    shadow_front    = 0;
    shadow_count    = 0;
    peak_count      = 0;

    key_pool[0] = KEY_MAX;
    key_pool[1] = KEY_MIN;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < 8; i++) key_pool[i] = $urandom;

    // empty deque, then extremes, duplicates and range checks
    directed_rows.push_back(typed_row(FUNC_READ, 0, 0, STATUS_EMPTY, 0, 0));
    directed_rows.push_back(typed_row(FUNC_DELETE_VALUE, 0, 0, STATUS_EMPTY, 0, 0));
    directed_rows.push_back(typed_row(FUNC_DELETE_FRONT, 0, 0, STATUS_EMPTY, 0, 0));
    directed_rows.push_back(typed_row(FUNC_DELETE_BACK, 0, 0, STATUS_EMPTY, 0, 0));
    directed_rows.push_back(typed_row(FUNC_NOP_5, -1, 1023, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(FUNC_NOP_7, KEY_MIN, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(FUNC_INSERT_FRONT, KEY_MAX, 0, STATUS_OK, 0, 1));
    directed_rows.push_back(typed_row(FUNC_INSERT_FRONT, KEY_MIN, 0, STATUS_OK, 0, 2));
    directed_rows.push_back(typed_row(FUNC_INSERT_FRONT, -1, 0, STATUS_OK, 0, 3));
    directed_rows.push_back(typed_row(FUNC_INSERT_FRONT, 0, 0, STATUS_OK, 0, 4));
    directed_rows.push_back(typed_row(FUNC_READ, 0, 3, STATUS_OK, KEY_MAX, 4));
    directed_rows.push_back(typed_row(FUNC_READ, 0, 4, STATUS_RANGE, 0, 4));
    directed_rows.push_back(typed_row(FUNC_READ, 0, 1023, STATUS_RANGE, 0, 4));
    directed_rows.push_back(typed_row(FUNC_DELETE_VALUE, 12345, 0, STATUS_NOT_FOUND, 0, 4));
    directed_rows.push_back(typed_row(FUNC_INSERT_FRONT, -1, 0, STATUS_OK, 0, 5));
    directed_rows.push_back(typed_row(FUNC_DELETE_VALUE, -1, 0, STATUS_OK, 0, 4));
    directed_rows.push_back(predicted_row(FUNC_READ, 0, 1));
    directed_rows.push_back(typed_row(FUNC_DELETE_VALUE, KEY_MIN, 0, STATUS_OK, 0, 3));
    directed_rows.push_back(predicted_row(FUNC_READ, 0, 2));
    directed_rows.push_back(typed_row(FUNC_DELETE_FRONT, 0, 0, STATUS_OK, 0, 2));
    directed_rows.push_back(typed_row(FUNC_DELETE_BACK, 0, 0, STATUS_OK, 0, 1));
    directed_rows.push_back(typed_row(FUNC_NOP_6, KEY_MAX, 0, STATUS_OK, 0, 1));
    directed_rows.push_back(typed_row(FUNC_READ, 0, 0, STATUS_OK, -1, 1));
    directed_rows.push_back(typed_row(FUNC_DELETE_VALUE, -1, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(predicted_row(FUNC_READ, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_op(directed_rows[i].func, directed_rows[i].key, directed_rows[i].position,
              directed_rows[i].typed, directed_rows[i].result);

    // small deque with a long output hold-off partway through
    random_ops(400, 40, 150);
    no_idle = 1'b1;
    random_ops(100, 40, -1);
    no_idle = 1'b0;

    // move the ring origin, then fill so that shifts cross the wrap point
    repeat (4) begin
      send_op(FUNC_INSERT_FRONT, pick_key(), POS_W'($urandom), 1'b0, '0);
      send_op(FUNC_DELETE_BACK, pick_key(), POS_W'($urandom), 1'b0, '0);
    end
    while (shadow_count < CAPACITY)
      send_op(FUNC_INSERT_FRONT, $urandom, POS_W'($urandom), 1'b0, '0);
    repeat (2) send_op(FUNC_INSERT_FRONT, pick_key(), POS_W'($urandom), 1'b0, '0);
    send_op(FUNC_READ, 0, 1023, 1'b0, '0);
    send_op(FUNC_READ, 0, 0, 1'b0, '0);
    repeat (6) begin
      key = shadow_store[(shadow_front + $urandom_range(0, 40)) % CAPACITY];
      send_op(FUNC_DELETE_VALUE, key, POS_W'($urandom), 1'b0, '0);
    end
    send_op(FUNC_DELETE_VALUE, $urandom, POS_W'($urandom), 1'b0, '0);
    send_op(FUNC_DELETE_FRONT, 0, 0, 1'b0, '0);
    while (shadow_count < CAPACITY)
      send_op(FUNC_INSERT_FRONT, $urandom, POS_W'($urandom), 1'b0, '0);
    send_op(FUNC_INSERT_FRONT, KEY_MAX, 0, 1'b0, '0);
    send_op(FUNC_DELETE_BACK, 0, 0, 1'b0, '0);
    send_op(FUNC_READ, 0, POS_W'($urandom), 1'b0, '0);
    random_ops(100, 35, -1);
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d responses, peak occupancy %0d of %0d",
             sent_count, result_count, peak_count, CAPACITY);
    $display("statuses seen: ok %0d, not found %0d, empty %0d, full %0d, range %0d; errors %0d",
             status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND], status_seen[STATUS_EMPTY],
             status_seen[STATUS_FULL], status_seen[STATUS_RANGE], error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/rdd_pkg.sv
sv/rdd_req_if.sv
sv/rdd_rsp_if.sv
sv/rdd_ram.sv
sv/rdd_wrap_add.sv
sv/rdd_ctrl.sv
sv/ring_deque_delete_by_value_unit.sv
tb/sv/tb_top.sv
